@@ rtl/hdh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hdh_pkg: shared types and constants of the djb2-based HMAC tag block
// Holds the djb2 seed and step, the pad bytes, the key layout and the item
// type that travels from the front end to the hash engine.
// ---------------------------------------------------------------------------
package hdh_pkg;

  localparam logic [31:0] DJB_SEED  = 32'd5381;
  localparam int          DJB_SHIFT = 5;
  localparam logic [7:0]  PAD_INNER = 8'h36;
  localparam logic [7:0]  PAD_OUTER = 8'h5C;
  localparam int          KEY_BYTES = 64;
  localparam int          KEY_WORDS = 8;
  localparam int          CNT_W     = $clog2(KEY_BYTES);
  localparam int          CFG_IDX_W = 4;
  localparam int          TAIL_BYTES = 4;

  typedef logic [KEY_WORDS-1:0][63:0]  hdh_key_words_t;
  typedef logic [KEY_BYTES-1:0][7:0]   hdh_key_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } hdh_item_t;

  function automatic logic [31:0] djb_absorb(input logic [31:0] h, input logic [7:0] b);
    djb_absorb = (h << DJB_SHIFT) + h + {24'd0, b};
  endfunction

endpackage
`default_nettype wire

@@ rtl/hdh_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hdh_front: input acceptance and item queue
// Takes stream transactions, drops items that carry no byte and end nothing,
// and queues the rest for the hash engine.
// ---------------------------------------------------------------------------
module hdh_front import hdh_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic      in_byte_present,
  input  wire logic      in_last_byte,
  output logic           q_valid,
  output hdh_item_t      q_item,
  input  wire logic      q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  hdh_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_QW-1:0] cnt_r;
  logic              accept;
  logic              push;
  logic              pop;

  assign in_tready = (cnt_r != CNT_FULL);
  assign accept    = in_tvalid && in_tready;
  // An item with neither a byte nor an end mark has no effect at all.
  assign push      = accept && (in_byte_present || in_last_byte);
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data_byte: in_data_byte, byte_present: in_byte_present,
                           last_byte: in_last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_FULL && !pop) |=> (cnt_r == CNT_FULL))
    else $error("queue count changed while full without a pop");

endmodule
`default_nettype wire

@@ rtl/hdh_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hdh_back: djb2 hash engine and result register
// Absorbs the inner pad when a message opens, message bytes one per cycle
// while items wait, then the outer pad and the four inner-hash bytes; holds the tag.
// ---------------------------------------------------------------------------
module hdh_back import hdh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hdh_key_t    key,
  input  wire logic        q_valid,
  input  wire hdh_item_t   q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INNER,
    ST_OUTER,
    ST_TAIL,
    ST_FIN
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(KEY_BYTES - 1);
  localparam logic [CNT_W-1:0] TAIL_LAST = CNT_W'(TAIL_BYTES - 1);

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      hash_r;
  logic [31:0]      outer_r;
  logic             in_msg_r;
  hdh_item_t        item_r;
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic [7:0]       key_byte;
  logic [7:0]       tail_byte;
  logic [31:0]      hash_item;
  logic [31:0]      inner_step;
  hdh_item_t        cur_item;

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign key_byte   = key[cnt_r];
  assign tail_byte  = hash_r[{cnt_r[1:0], 3'b000} +: 8];

  // The item being applied is the fresh one in IDLE, the held one after the pad.
  assign cur_item  = (state_r == ST_IDLE) ? q_item : item_r;
  assign hash_item = cur_item.byte_present ? djb_absorb(hash_r, cur_item.data_byte)
                                           : hash_r;
  assign inner_step = djb_absorb((cnt_r == '0) ? DJB_SEED : hash_r, key_byte ^ PAD_INNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hash_r      <= DJB_SEED;
      outer_r     <= DJB_SEED;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The finish step reloads the result register on its own.
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            if (!in_msg_r) begin
              cnt_r   <= '0;
              state_r <= ST_INNER;
            end else begin
              hash_r <= hash_item;
              if (q_item.last_byte) begin
                cnt_r    <= '0;
                outer_r  <= DJB_SEED;
                in_msg_r <= 1'b0;
                state_r  <= ST_OUTER;
              end
            end
          end
        end
        ST_INNER: begin
          // The count wraps to zero after the last key byte, ready for the outer pad.
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != CNT_LAST) begin
            hash_r <= inner_step;
          end else begin
            // The opening item is applied in the step that finishes the pad.
            hash_r <= item_r.byte_present ? djb_absorb(inner_step, item_r.data_byte)
                                          : inner_step;
            if (item_r.last_byte) begin
              outer_r <= DJB_SEED;
              state_r <= ST_OUTER;
            end else begin
              in_msg_r <= 1'b1;
              state_r  <= ST_IDLE;
            end
          end
        end
        ST_OUTER: begin
          outer_r <= djb_absorb(outer_r, key_byte ^ PAD_OUTER);
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          outer_r <= djb_absorb(outer_r, tail_byte);
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == TAIL_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= outer_r;
            hash_r      <= DJB_SEED;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_load_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("tag loaded outside the finish step");

  a_inner_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INNER) |-> !in_msg_r)
    else $error("inner pad absorbed while a message is open");

  a_seed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_msg_r) |-> (hash_r == DJB_SEED))
    else $error("running hash not at seed with no message open");

endmodule
`default_nettype wire

@@ rtl/hmac_over_djb2_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hmac_over_djb2_hash: HMAC-style 32-bit tag over a byte stream using djb2
// Key registers, an input front end with a short queue, and a hash engine.
//
//  channel | dir | payload                                     | handshake
//  in_     | in  | tdata: data_byte; tuser: byte_present; tlast: last_byte | tvalid/tready
//  out_    | out | tdata: mac                                  | tvalid/tready
//  cfg_    | in  | index: key word 0..7; data: 64-bit key word | valid/ready
//
// The engine absorbs a byte inside an open message straight from the queue.
// The item that opens a message first adds the inner pad over the key bytes;
// the last item adds the outer pad, the four inner-hash bytes and a step to
// load the result register. Reset is synchronous; key words reset to zero.
// Either side may stall: the queue absorbs input while the engine is busy,
// and the engine waits in its finish step while a tag is not yet taken.
// ---------------------------------------------------------------------------
module hmac_over_djb2_hash import hdh_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] data_byte
  input  wire logic                 in_tuser,   // [0] byte_present
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // [31:0] mac
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  hdh_key_words_t key_r;
  hdh_key_t       key_bytes;
  logic           q_valid;
  hdh_item_t      q_item;
  logic           q_pop;

  assign cfg_ready = 1'b1;
  assign key_bytes = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
      key_r[cfg_index[$clog2(KEY_WORDS)-1:0]] <= cfg_data;
    end
  end

  hdh_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_data_byte    (in_tdata),
    .in_byte_present (in_tuser),
    .in_last_byte    (in_tlast),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  hdh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        (key_bytes),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ tb/hmac_over_djb2_hash_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmac_over_djb2_hash_tb: self-checking testbench for the djb2 HMAC tag block
// Sends byte messages, loads a range of keys between messages, and checks
// every tag against a scoreboard that models the inner and outer pad passes.
// ---------------------------------------------------------------------------
module hmac_over_djb2_hash_tb;
  import hdh_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int PHASE_ITEMS    = 250;
  localparam int SETTLE_CYCLES  = 160;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum int {KEY_ZERO, KEY_ONES, KEY_INNER_PAD, KEY_RANDOM, KEY_SHORT} key_style_t;

  class hmac_tag_scoreboard;
    logic [63:0] key_words [KEY_WORDS];
    logic [31:0] run_hash;
    bit          msg_open;
    logic [31:0] tags_due [$];
    int          errors;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      run_hash = DJB_SEED;
      msg_open = 1'b0;
      errors   = 0;
    endfunction

    function void write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
      if (idx < KEY_WORDS) key_words[idx] = value;
    endfunction

    // djb2 over the 64 key bytes, each XOR the pad byte.
    function logic [31:0] pad_hash(logic [7:0] pad);
      logic [31:0] h;
      logic [7:0]  kb;
      h = DJB_SEED;
      for (int i = 0; i < KEY_BYTES; i++) begin
        kb = key_words[i / 8][(i % 8) * 8 +: 8];
        h  = h * 32'd33 + {24'd0, kb ^ pad};
      end
      return h;
    endfunction

    function void note_item(logic [7:0] data, logic present, logic last);
      logic [31:0] tag;
      if (!present && !last) return;
      if (!msg_open) begin
        run_hash = pad_hash(PAD_INNER);
        msg_open = 1'b1;
      end
      if (present) run_hash = run_hash * 32'd33 + {24'd0, data};
      if (!last) return;
      tag = pad_hash(PAD_OUTER);
      for (int k = 0; k < 4; k++) tag = tag * 32'd33 + {24'd0, run_hash[8 * k +: 8]};
      tags_due.push_back(tag);
      run_hash = DJB_SEED;
      msg_open = 1'b0;
    endfunction

    function void check_tag(logic [31:0] mac);
      logic [31:0] want;
      if (tags_due.size() == 0) begin
        $display("%0t: tag with none expected: expected none, actual %08h", $time, mac);
        errors++;
        return;
      end
      want = tags_due.pop_front();
      if (mac !== want) begin
        $display("%0t: wrong tag: expected %08h, actual %08h", $time, want, mac);
        errors++;
      end
    endfunction

    function int tags_pending();
      return tags_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  hmac_tag_scoreboard sb;
  int  items_sent;
  int  idle_cycles;
  int  stall_left;
  int  ready_gap;
  bit  steady;

  hmac_over_djb2_hash u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_tag(out_tdata);
      if (in_tvalid && in_tready) sb.note_item(in_tdata, in_tuser, in_tlast);
      if (cfg_valid && cfg_ready) sb.write_key(cfg_index, cfg_data);
    end
  end

  always @(negedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      ready_gap = pick_gap();
      out_tready <= (ready_gap == 0);
      if (ready_gap > 0) stall_left <= ready_gap - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("hmac_over_djb2_hash: mismatch");
    $finish;
  end

  // Called at a falling edge; leaves tvalid high so the next item can follow
  // without a bubble.
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (present || last) items_sent++;
  endtask

  task automatic send_message(input int len, input bit bare_end, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Holds the sender until every tag is out and the engine has gone quiet.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.tags_pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_key(input key_style_t style, input bit with_stray);
    logic [63:0] w;
    int          key_len;
    key_len = $urandom_range(1, KEY_BYTES - 1);
    for (int i = 0; i < KEY_WORDS; i++) begin
      for (int k = 0; k < 8; k++) begin
        case (style)
          KEY_ZERO:      w[8 * k +: 8] = 8'h00;
          KEY_ONES:      w[8 * k +: 8] = 8'hFF;
          KEY_INNER_PAD: w[8 * k +: 8] = PAD_INNER;
          KEY_RANDOM:    w[8 * k +: 8] = 8'($urandom_range(0, 255));
          default:       w[8 * k +: 8] = (8 * i + k < key_len) ? 8'($urandom_range(0, 255))
                                                               : 8'h00;
        endcase
      end
      write_cfg(CFG_IDX_W'(i), w);
    end
    // An index past the key words must leave the key alone.
    if (with_stray)
      write_cfg(CFG_IDX_W'(KEY_WORDS + $urandom_range(0, 7)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_message();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 5) len = 0;
    else if (r < 75) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 200);
    send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
  endtask

  initial begin
    key_style_t style;
    int         phase;
    int         phase_end;

    sb         = new();
    items_sent = 0;
    steady     = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset key of all zeros.
    send_item(8'hA5, 1'b0, 1'b0);           // empty item outside a message
    send_item(8'h5A, 1'b0, 1'b1);           // empty message
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);           // empty item inside a message
    send_item(8'h3C, 1'b0, 1'b1);           // bare end marker closes it
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'hAA, 1'b0, 1'b0);
    quiesce();
    load_key(KEY_ONES, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_message(3, 1'b1, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      quiesce();
      case (phase)
        0:       style = KEY_RANDOM;
        1:       style = KEY_SHORT;
        2:       style = KEY_INNER_PAD;
        3:       style = KEY_ZERO;
        4:       style = KEY_ONES;
        default: style = ($urandom_range(0, 1) == 0) ? KEY_RANDOM : KEY_SHORT;
      endcase
      load_key(style, $urandom_range(0, 2) == 0);
      steady <= ($urandom_range(0, 3) == 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 19) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        else
          random_message();
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (sb.tags_pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("hmac_over_djb2_hash: match");
    else
      $display("hmac_over_djb2_hash: mismatch");
    $finish;
  end

endmodule
